/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// concurrent check helpers clocked on clock and held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SM4_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// next-cycle implication
`define SM4_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`else

`define SM4_ASSERT_IMPL(name, ante, cons)
`define SM4_ASSERT_NEXT(name, ante, cons)

`endif

`endif

/* sv/sm4_pkg.sv */
// ----------------------------------------------------------------------------
// sm4_pkg
// shared constants, tables and round functions of the sm4 cipher core
// ----------------------------------------------------------------------------
package sm4_pkg;

   localparam int WORD_W     = 32;
   localparam int DEF_ROUNDS = 32;
   localparam int RND_IDX_W  = 5;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   // register index codes (paddr[4:3])
   localparam logic [1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW  = 2'd1;
   localparam logic [1:0] CSR_DECRYPT  = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FWD,
      CELL_BACK
   } cell_op_type;

   localparam logic [WORD_W-1:0] FK_WORDS [4] = '{
      32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
   };

   localparam logic [7:0] SBOX_TABLE [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // byte-wise s-box substitution
   function automatic logic [WORD_W-1:0] tau(input logic [WORD_W-1:0] a);
      return {SBOX_TABLE[a[31:24]], SBOX_TABLE[a[23:16]],
              SBOX_TABLE[a[15:8]], SBOX_TABLE[a[7:0]]};
   endfunction

   // data linear transform: rotations by 2, 10, 18, 24
   function automatic logic [WORD_W-1:0] l_data(input logic [WORD_W-1:0] b);
      return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
               ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
   endfunction

   // key schedule linear transform: rotations by 13, 23
   function automatic logic [WORD_W-1:0] l_key(input logic [WORD_W-1:0] b);
      return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
   endfunction

   // ck constant of round idx, byte j is (4*idx+j)*7 mod 256
   function automatic logic [WORD_W-1:0] ck_word(input logic [RND_IDX_W-1:0] idx);
      logic [WORD_W-1:0] w;
      logic [9:0]        p;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         p = 10'({idx, 2'(j)}) * 10'd7;
         w = {w[23:0], p[7:0]};
      end
      return w;
   endfunction

endpackage

/* sv/sm4_cell.sv */
// ----------------------------------------------------------------------------
// sm4_cell
// one word of the shift chain: holds, loads, or takes a neighbor's word
// ----------------------------------------------------------------------------
module sm4_cell
   import sm4_pkg::*;
(
   input  logic              clock,
   input  cell_op_type       op,
   input  logic [WORD_W-1:0] load_word,
   input  logic [WORD_W-1:0] next_word,
   input  logic [WORD_W-1:0] prev_word,
   output logic [WORD_W-1:0] word
);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      case (op)
         CELL_LOAD: word_in = load_word;
         CELL_FWD:  word_in = next_word;
         CELL_BACK: word_in = prev_word;
         default:   word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

/* sv/sm4_round_fn.sv */
// ----------------------------------------------------------------------------
// sm4_round_fn
// shared round unit for cipher rounds and key schedule steps
// ----------------------------------------------------------------------------
module sm4_round_fn
   import sm4_pkg::*;
(
   input  logic [WORD_W-1:0] w0,
   input  logic [WORD_W-1:0] w1,
   input  logic [WORD_W-1:0] w2,
   input  logic [WORD_W-1:0] w3,
   input  logic [WORD_W-1:0] add_word,
   input  logic              key_sched,
   output logic [WORD_W-1:0] new_word
);

   logic [WORD_W-1:0] mix;
   logic [WORD_W-1:0] subst;

   always_comb begin
      mix      = w1 ^ w2 ^ w3 ^ add_word;
      subst    = tau(mix);
      new_word = w0 ^ (key_sched ? l_key(subst) : l_data(subst));
   end

endmodule

/* sv/sm4_block_cipher.sv */
// ----------------------------------------------------------------------------
// sm4_block_cipher
// sm4 block encrypt / decrypt core with on-chip round key expansion
// ----------------------------------------------------------------------------
// A 128-bit block is taken on the req channel and its SM4 encryption (or
// decryption when the decrypt register is set) comes back on the rsp channel.
// The block works on one block at a time: after a block is transferred, the
// four-word chain is loaded, ROUNDS rounds run through the single shared
// round unit, and the result moves into the output register (once the
// previous result has left it) before the next block is taken. The output
// register frees the chain, so a new block is taken while a result still
// waits on rsp. After reset and after every write of key_high or key_low the
// round keys are expanded again, which keeps req_stall high until expansion
// is done; the same round unit and word chain do this, shifting each new round
// key into a ring of ROUNDS key cells. The ring rotates one way for
// encryption and the other way for decryption, so the round key in use is
// always at a fixed tap and the ring is back in place when a block is done.
// Registers (64-bit APB data, paddr[4:3] decoded): key_high at 0x00, key_low
// at 0x08, decrypt at 0x10; index 0x18 is ignored on write and reads as zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sm4_block_cipher
   import sm4_pkg::*;
#(
   parameter int ROUNDS = DEF_ROUNDS
)
(
   input  logic                  clock,
   input  logic                  reset,

   // block input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [63:0]           req_block_high,
   input  logic [63:0]           req_block_low,

   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [63:0]           rsp_result_high,
   output logic [63:0]           rsp_result_low,

   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int CNT_W = $clog2(ROUNDS);
   localparam logic [CNT_W-1:0] LAST_RND = CNT_W'(ROUNDS - 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_KLOAD  = 5'b00010,
      ST_EXPAND = 5'b00100,
      ST_RUN    = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              keys_valid_ff, keys_valid_in;
   logic [63:0]       key_high_ff, key_high_in;
   logic [63:0]       key_low_ff, key_low_in;
   logic              decrypt_ff, decrypt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [63:0]       rsp_high_ff, rsp_high_in;
   logic [63:0]       rsp_low_ff, rsp_low_in;

   logic              csr_wr;
   logic [1:0]        csr_idx;
   logic              key_wr;
   logic              req_xfer;
   logic              out_free;

   cell_op_type       data_op;
   cell_op_type       ring_op;
   logic [WORD_W-1:0] data_q    [4];
   logic [WORD_W-1:0] data_load [4];
   logic [WORD_W-1:0] rk_q      [ROUNDS];
   logic [WORD_W-1:0] ring_tail;
   logic [WORD_W-1:0] add_word;
   logic [WORD_W-1:0] new_word;
   logic              expanding;

   // ------------------------------------------------------------------
   // register port
   // ------------------------------------------------------------------
   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_W-1:3];
   assign csr_wr  = psel && penable && pwrite;
   assign key_wr  = csr_wr && ((csr_idx == CSR_KEY_HIGH) || (csr_idx == CSR_KEY_LOW));

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      decrypt_in  = decrypt_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            CSR_KEY_HIGH: key_high_in = pwdata;
            CSR_KEY_LOW:  key_low_in  = pwdata;
            CSR_DECRYPT:  decrypt_in  = pwdata[0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_KEY_HIGH: prdata = key_high_ff;
         CSR_KEY_LOW:  prdata = key_low_ff;
         CSR_DECRYPT:  prdata = {{(CSR_DATA_W-1){1'b0}}, decrypt_ff};
         default:      prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign expanding = (state_ff == ST_EXPAND);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      keys_valid_in = keys_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cnt_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_KLOAD: begin
            cnt_in   = '0;
            state_in = ST_EXPAND;
         end
         ST_EXPAND: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_RND) begin
               keys_valid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_RND) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_KLOAD;
      endcase
      // any key write restarts the schedule
      if (key_wr) begin
         keys_valid_in = 1'b0;
         state_in      = ST_KLOAD;
      end
   end

   // ------------------------------------------------------------------
   // four-word data chain
   // ------------------------------------------------------------------
   always_comb begin
      if (state_ff == ST_KLOAD) begin
         data_load[0] = key_high_ff[63:32] ^ FK_WORDS[0];
         data_load[1] = key_high_ff[31:0]  ^ FK_WORDS[1];
         data_load[2] = key_low_ff[63:32]  ^ FK_WORDS[2];
         data_load[3] = key_low_ff[31:0]   ^ FK_WORDS[3];
      end else begin
         data_load[0] = req_block_high[63:32];
         data_load[1] = req_block_high[31:0];
         data_load[2] = req_block_low[63:32];
         data_load[3] = req_block_low[31:0];
      end

      if ((state_ff == ST_KLOAD) || req_xfer) begin
         data_op = CELL_LOAD;
      end else if (expanding || (state_ff == ST_RUN)) begin
         data_op = CELL_FWD;
      end else begin
         data_op = CELL_HOLD;
      end

      if (expanding || ((state_ff == ST_RUN) && !decrypt_ff)) begin
         ring_op = CELL_FWD;
      end else if (state_ff == ST_RUN) begin
         ring_op = CELL_BACK;
      end else begin
         ring_op = CELL_HOLD;
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_data
      if (i == 3) begin : g_head
         sm4_cell u_cell (
            .clock     (clock),
            .op        (data_op),
            .load_word (data_load[i]),
            .next_word (new_word),
            .prev_word (data_q[i-1]),
            .word      (data_q[i])
         );
      end else if (i == 0) begin : g_tail
         sm4_cell u_cell (
            .clock     (clock),
            .op        (data_op),
            .load_word (data_load[i]),
            .next_word (data_q[i+1]),
            .prev_word (data_q[3]),
            .word      (data_q[i])
         );
      end else begin : g_mid
         sm4_cell u_cell (
            .clock     (clock),
            .op        (data_op),
            .load_word (data_load[i]),
            .next_word (data_q[i+1]),
            .prev_word (data_q[i-1]),
            .word      (data_q[i])
         );
      end
   end

   // ------------------------------------------------------------------
   // round key ring
   // ------------------------------------------------------------------
   // during expansion the fresh key enters at the top, otherwise it wraps
   assign ring_tail = expanding ? new_word : rk_q[0];

   for (genvar j = 0; j < ROUNDS; j++) begin : g_ring
      localparam int NXT = (j + 1) % ROUNDS;
      localparam int PRV = (j + ROUNDS - 1) % ROUNDS;
      sm4_cell u_cell (
         .clock     (clock),
         .op        (ring_op),
         .load_word (new_word),
         .next_word ((j == ROUNDS - 1) ? ring_tail : rk_q[NXT]),
         .prev_word (rk_q[PRV]),
         .word      (rk_q[j])
      );
   end

   // ------------------------------------------------------------------
   // shared round unit
   // ------------------------------------------------------------------
   // encrypt taps the bottom of the ring, decrypt the top
   always_comb begin
      if (expanding) begin
         add_word = ck_word(RND_IDX_W'(cnt_ff));
      end else if (decrypt_ff) begin
         add_word = rk_q[ROUNDS-1];
      end else begin
         add_word = rk_q[0];
      end
   end

   sm4_round_fn u_round (
      .w0        (data_q[0]),
      .w1        (data_q[1]),
      .w2        (data_q[2]),
      .w3        (data_q[3]),
      .add_word  (add_word),
      .key_sched (expanding),
      .new_word  (new_word)
   );

   // ------------------------------------------------------------------
   // output register, final word order reversed
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_high_in  = rsp_high_ff;
      rsp_low_in   = rsp_low_ff;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_high_in  = {data_q[3], data_q[2]};
         rsp_low_in   = {data_q[1], data_q[0]};
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_high = rsp_high_ff;
   assign rsp_result_low  = rsp_low_ff;

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_KLOAD;
         cnt_ff        <= '0;
         keys_valid_ff <= 1'b0;
         key_high_ff   <= '0;
         key_low_ff    <= '0;
         decrypt_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         keys_valid_ff <= keys_valid_in;
         key_high_ff   <= key_high_in;
         key_low_ff    <= key_low_in;
         decrypt_ff    <= decrypt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_high_ff <= rsp_high_in;
      rsp_low_ff  <= rsp_low_in;
   end

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // a block is only taken once the schedule is complete
   `SM4_ASSERT_IMPL(a_keys_ready_on_xfer, req_xfer, keys_valid_ff)
   // a key write always invalidates the schedule
   `SM4_ASSERT_NEXT(a_key_wr_clears, key_wr, !keys_valid_ff)
   // a taken block starts the rounds from the first one
   `SM4_ASSERT_NEXT(a_xfer_starts_run, req_xfer && !key_wr,
                    (state_ff == ST_RUN) && (cnt_ff == '0))

endmodule
